// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion helper macros
// Shared wrappers around concurrent assertions, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/fmslw_pkg.sv =====
// ----------------------------------------------------------------------------
// fmslw_pkg
// Types and constants for the four-channel slew limiter with link watchdog.
// ----------------------------------------------------------------------------
package fmslw_pkg;

  localparam int NUM_CH    = 4;
  localparam int CMD_W     = 2;
  localparam int SPEED_W   = 9;
  localparam int CFG_W     = 8;
  localparam int PWM_W     = 8;
  localparam int APB_W     = 32;
  localparam int PADDR_W   = 4;
  localparam int REG_LSB   = 2;

  // stream payload layout
  localparam int S_TDATA_W     = 24;
  localparam int S_TUSER_W     = CMD_W;
  localparam int RIGHT_LSB     = 0;
  localparam int LEFT_LSB      = SPEED_W;
  localparam int CH_FIELD_W    = 1 + PWM_W;
  localparam int TIMED_OUT_BIT = NUM_CH * CH_FIELD_W;
  localparam int M_TDATA_W     = 40;

  localparam logic [PWM_W-1:0] PWM_MAX   = 8'hFF;
  localparam logic [CFG_W-1:0] COUNT_MAX = 8'hFF;

  // register reset values
  localparam logic [CFG_W-1:0] SLEW_STEP_RST     = 8'd1;
  localparam logic [CFG_W-1:0] MAX_PWM_RST       = 8'd255;
  localparam logic [CFG_W-1:0] TIMEOUT_LIMIT_RST = 8'd10;
  localparam logic [CFG_W-1:0] PRESCALE_TOP_RST  = 8'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 2'd0,
    CMD_PING     = 2'd1,
    CMD_PLATFORM = 2'd2
  } cmd_t;

  typedef enum logic [PADDR_W-REG_LSB-1:0] {
    REG_SLEW_STEP     = 2'd0,
    REG_MAX_PWM       = 2'd1,
    REG_TIMEOUT_LIMIT = 2'd2,
    REG_PRESCALE_TOP  = 2'd3
  } reg_idx_t;

endpackage

// ===== sv/four_motor_slew_limiter_watchdog_top.sv =====
// ----------------------------------------------------------------------------
// four_motor_slew_limiter_watchdog_top: 4-channel motor slew limiter, watchdog
// Path: input reg, then result reg. Stalls only while the result is held off.
// Throughput: one transaction per cycle when not stalled; all four channels
// update in one pass.
// Reset (rst, sync, active high): registers to defaults, all motor state zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module four_motor_slew_limiter_watchdog_top #(
  parameter int MAG_WIDTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // right_speed[8:0], left_speed[17:9], zero pad
  input  logic [fmslw_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // cmd[1:0]
  input  logic [fmslw_pkg::S_TUSER_W-1:0]    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // motor0_dir[0], motor0_pwm[8:1], motor1_dir[9], motor1_pwm[17:10],
  // motor2_dir[18], motor2_pwm[26:19], motor3_dir[27], motor3_pwm[35:28],
  // timed_out[36], zero pad
  output logic [fmslw_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fmslw_pkg::PADDR_W-1:0]      paddr,
  input  logic [fmslw_pkg::APB_W-1:0]        pwdata,
  output logic [fmslw_pkg::APB_W-1:0]        prdata,
  output logic                               pready
);

  localparam int NCH = fmslw_pkg::NUM_CH;

  typedef logic [MAG_WIDTH-1:0] mag_t;
  typedef logic [MAG_WIDTH:0]   sum_t;

  localparam mag_t MAG_CLAMP = mag_t'(fmslw_pkg::PWM_MAX);

  // configuration
  logic [fmslw_pkg::CFG_W-1:0] slew_step;
  logic [fmslw_pkg::CFG_W-1:0] max_pwm;
  logic [fmslw_pkg::CFG_W-1:0] timeout_limit;
  logic [fmslw_pkg::CFG_W-1:0] prescale_top;

  // channel and watchdog state
  logic                        actual_dir [NCH];
  mag_t                        actual_mag [NCH];
  logic                        target_dir [NCH];
  mag_t                        target_mag [NCH];
  logic [fmslw_pkg::CFG_W-1:0] silence_count;
  logic                        timeout_flag;
  logic [fmslw_pkg::CFG_W-1:0] tick_prescaler;

  logic                        actual_dir_next [NCH];
  mag_t                        actual_mag_next [NCH];
  logic                        target_dir_next [NCH];
  mag_t                        target_mag_next [NCH];
  logic [fmslw_pkg::CFG_W-1:0] silence_count_next;
  logic                        timeout_flag_next;
  logic [fmslw_pkg::CFG_W-1:0] tick_prescaler_next;

  // input stage
  logic                          in_valid;
  logic [fmslw_pkg::CMD_W-1:0]   in_cmd;
  logic [fmslw_pkg::SPEED_W-1:0] in_right;
  logic [fmslw_pkg::SPEED_W-1:0] in_left;

  // result stage
  logic                           out_valid;
  logic [fmslw_pkg::M_TDATA_W-1:0] out_data;
  logic [fmslw_pkg::M_TDATA_W-1:0] out_data_next;

  logic advance;
  logic cfg_write;

  // assertion helpers
  logic                     tick_adv;
  logic [NCH*MAG_WIDTH-1:0] mag_bus;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign pready        = 1'b1;
  assign cfg_write     = psel && penable && pwrite && pready;

  assign tick_adv = advance && (in_cmd == fmslw_pkg::CMD_TICK);
  assign mag_bus  = {actual_mag[3], actual_mag[2], actual_mag[1], actual_mag[0]};

  // Two's-complement speed to target magnitude, clamped to 8 bits
  function automatic mag_t speed_mag(input logic [fmslw_pkg::SPEED_W-1:0] v);
    logic [fmslw_pkg::SPEED_W-1:0] abs_v;
    abs_v = v[fmslw_pkg::SPEED_W-1] ? (~v + 1'b1) : v;
    return (abs_v > {1'b0, fmslw_pkg::PWM_MAX}) ? MAG_CLAMP
                                                : mag_t'(abs_v[fmslw_pkg::PWM_W-1:0]);
  endfunction

  always_comb begin
    sum_t cur;
    sum_t tgt;
    sum_t step;
    sum_t maxp;
    sum_t dn;
    sum_t up;
    sum_t nmag;
    logic [fmslw_pkg::CFG_W-1:0] cnt_inc;
    logic                        zero_drive;

    step = sum_t'(slew_step);
    maxp = sum_t'(max_pwm);
    zero_drive = timeout_flag;

    silence_count_next  = silence_count;
    timeout_flag_next   = timeout_flag;
    tick_prescaler_next = tick_prescaler;
    for (int k = 0; k < NCH; k++) begin
      actual_dir_next[k] = actual_dir[k];
      actual_mag_next[k] = actual_mag[k];
      target_dir_next[k] = target_dir[k];
      target_mag_next[k] = target_mag[k];
    end

    cnt_inc = (silence_count != fmslw_pkg::COUNT_MAX) ? silence_count + 1'b1
                                                      : silence_count;

    case (fmslw_pkg::cmd_t'(in_cmd))
      fmslw_pkg::CMD_TICK: begin
        for (int k = 0; k < NCH; k++) begin
          cur  = {1'b0, actual_mag[k]};
          tgt  = {1'b0, target_mag[k]};
          dn   = (cur > step) ? cur - step : '0;
          up   = cur + step;
          nmag = cur;
          if (zero_drive) begin
            nmag = '0;
          end else if (target_dir[k] != actual_dir[k]) begin
            // ramp down before reversing
            nmag = dn;
            if (dn == '0) actual_dir_next[k] = target_dir[k];
          end else if (cur > tgt) begin
            nmag = dn;
            if (nmag > maxp) nmag = maxp;
            if (nmag < tgt) nmag = tgt;
          end else if (cur < tgt) begin
            nmag = up;
            if (nmag > maxp) nmag = maxp;
            if (nmag > tgt) nmag = tgt;
          end
          actual_mag_next[k] = nmag[MAG_WIDTH-1:0];
        end
        if (tick_prescaler == '0) begin
          if (cnt_inc >= timeout_limit) begin
            silence_count_next = timeout_limit;
            timeout_flag_next  = 1'b1;
          end else begin
            silence_count_next = cnt_inc;
            timeout_flag_next  = 1'b0;
          end
        end
        tick_prescaler_next = (tick_prescaler >= prescale_top) ? '0
                                                               : tick_prescaler + 1'b1;
      end
      fmslw_pkg::CMD_PING: begin
        silence_count_next = '0;
      end
      fmslw_pkg::CMD_PLATFORM: begin
        silence_count_next = '0;
        // right side: negative drives dir 0; left side has opposite polarity
        for (int k = 0; k < NCH / 2; k++) begin
          target_dir_next[k] = ~in_right[fmslw_pkg::SPEED_W-1];
          target_mag_next[k] = speed_mag(in_right);
          target_dir_next[k + NCH / 2] = in_left[fmslw_pkg::SPEED_W-1];
          target_mag_next[k + NCH / 2] = speed_mag(in_left);
        end
      end
      default: begin
      end
    endcase

    // drive reported is zero whenever the flag was set before this transaction
    out_data_next = '0;
    for (int k = 0; k < NCH; k++) begin
      out_data_next[k * fmslw_pkg::CH_FIELD_W] = actual_dir_next[k] && !zero_drive;
      out_data_next[k * fmslw_pkg::CH_FIELD_W + 1 +: fmslw_pkg::PWM_W] =
        zero_drive ? '0 : actual_mag_next[k][fmslw_pkg::PWM_W-1:0];
    end
    out_data_next[fmslw_pkg::TIMED_OUT_BIT] = timeout_flag_next;
  end

  // register read
  always_comb begin
    prdata = '0;
    case (fmslw_pkg::reg_idx_t'(paddr[fmslw_pkg::PADDR_W-1:fmslw_pkg::REG_LSB]))
      fmslw_pkg::REG_SLEW_STEP:     prdata[fmslw_pkg::CFG_W-1:0] = slew_step;
      fmslw_pkg::REG_MAX_PWM:       prdata[fmslw_pkg::CFG_W-1:0] = max_pwm;
      fmslw_pkg::REG_TIMEOUT_LIMIT: prdata[fmslw_pkg::CFG_W-1:0] = timeout_limit;
      fmslw_pkg::REG_PRESCALE_TOP:  prdata[fmslw_pkg::CFG_W-1:0] = prescale_top;
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      out_valid      <= 1'b0;
      slew_step      <= fmslw_pkg::SLEW_STEP_RST;
      max_pwm        <= fmslw_pkg::MAX_PWM_RST;
      timeout_limit  <= fmslw_pkg::TIMEOUT_LIMIT_RST;
      prescale_top   <= fmslw_pkg::PRESCALE_TOP_RST;
      silence_count  <= '0;
      timeout_flag   <= 1'b0;
      tick_prescaler <= '0;
      for (int k = 0; k < NCH; k++) begin
        actual_dir[k] <= 1'b0;
        actual_mag[k] <= '0;
        target_dir[k] <= 1'b0;
        target_mag[k] <= '0;
      end
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (fmslw_pkg::reg_idx_t'(paddr[fmslw_pkg::PADDR_W-1:fmslw_pkg::REG_LSB]))
          fmslw_pkg::REG_SLEW_STEP:     slew_step     <= pwdata[fmslw_pkg::CFG_W-1:0];
          fmslw_pkg::REG_MAX_PWM:       max_pwm       <= pwdata[fmslw_pkg::CFG_W-1:0];
          fmslw_pkg::REG_TIMEOUT_LIMIT: timeout_limit <= pwdata[fmslw_pkg::CFG_W-1:0];
          fmslw_pkg::REG_PRESCALE_TOP:  prescale_top  <= pwdata[fmslw_pkg::CFG_W-1:0];
          default: begin
          end
        endcase
      end
      if (advance) begin
        silence_count  <= silence_count_next;
        timeout_flag   <= timeout_flag_next;
        tick_prescaler <= tick_prescaler_next;
        for (int k = 0; k < NCH; k++) begin
          actual_dir[k] <= actual_dir_next[k];
          actual_mag[k] <= actual_mag_next[k];
          target_dir[k] <= target_dir_next[k];
          target_mag[k] <= target_mag_next[k];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd   <= s_axis_tuser[fmslw_pkg::CMD_W-1:0];
      in_right <= s_axis_tdata[fmslw_pkg::RIGHT_LSB +: fmslw_pkg::SPEED_W];
      in_left  <= s_axis_tdata[fmslw_pkg::LEFT_LSB +: fmslw_pkg::SPEED_W];
    end
    if (advance) begin
      out_data <= out_data_next;
    end
  end

  `ASSERT_NEXT(a_adv_out_valid, clk, rst, advance, out_valid, "transaction gave no result")

  `ASSERT_NEXT(a_in_held, clk, rst, in_valid && !advance, in_valid, "pending input dropped")

  `ASSERT_NEXT(a_timeout_zero, clk, rst, tick_adv && timeout_flag, ~|mag_bus, "timed-out drive")

  `ASSERT_NEXT(a_cmd_no_slew, clk, rst, advance && !tick_adv, $stable(mag_bus), "command slewed")

endmodule
